// ===== rtl/fae_pkg.sv =====
package fae_pkg;

    localparam int unsigned ExpW  = 8;
    localparam int unsigned ManW  = 23;
    localparam int unsigned WordW = 32;
    localparam int unsigned TolW  = 31;
    localparam int unsigned UlpW  = 32;
    // significand with hidden bit, 3 guard bits and headroom for carry
    localparam int unsigned SigW  = ManW + 1 + 3 + 1;

    localparam logic [TolW-1:0] AbsTolReset = 31'h3400_0000;
    localparam logic [UlpW-1:0] UlpTolReset = 32'd4;

    localparam logic [0:0] RegAbsTol = 1'b0;
    localparam logic [0:0] RegUlpTol = 1'b1;

    // aligned operands, larger magnitude first
    typedef struct packed {
        logic            valid;
        logic            inv;
        logic            same_sign;
        logic            ulp_ok;
        logic [ExpW-1:0] exp;
        logic [SigW-1:0] big;
        logic [SigW-1:0] lesser;
        logic            sub;
    } t_s1;

    // raw difference magnitude
    typedef struct packed {
        logic            valid;
        logic            inv;
        logic            same_sign;
        logic            ulp_ok;
        logic [ExpW-1:0] exp;
        logic [SigW:0]   sum;
    } t_s2;

    typedef struct packed {
        logic valid;
        logic equal;
        logic inv;
    } t_res;

endpackage

// ===== rtl/float_almost_equal_compare_top.sv =====
// channel | valid   | stall   | payload
// in      | i_valid | o_stall | i_a_bits, i_b_bits
// out     | o_valid | i_stall | o_equal, o_invalid
// One transaction per cycle while the pipeline is not stalled; registered stages: align, add, normalize/round.
// Reset is synchronous, active low, clears valid bits and loads the reset
// tolerances.
// i_stall freezes the whole pipeline only when the output stage holds an item;
// o_stall then follows it.
module float_almost_equal_compare_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [fae_pkg::WordW-1:0] i_a_bits,
    input  logic [fae_pkg::WordW-1:0] i_b_bits,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_equal,
    output logic                      o_invalid,
    input  logic                      i_cfg_we,
    input  logic [0:0]                i_cfg_idx,
    input  logic [fae_pkg::UlpW-1:0]  i_cfg_data
);
    logic [fae_pkg::TolW-1:0] r_abs_tol;
    logic [fae_pkg::UlpW-1:0] r_ulp_tol;
    logic                     en;
    fae_pkg::t_s1             s1;
    fae_pkg::t_s2             s2;
    fae_pkg::t_res            res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abs_tol <= fae_pkg::AbsTolReset;
            r_ulp_tol <= fae_pkg::UlpTolReset;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == fae_pkg::RegAbsTol) begin
                r_abs_tol <= i_cfg_data[fae_pkg::TolW-1:0];
            end else begin
                r_ulp_tol <= i_cfg_data;
            end
        end
    end

    assign en      = !(res.valid && i_stall);
    assign o_stall = !en;

    fae_align u_align (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_valid),
        .i_a(i_a_bits), .i_b(i_b_bits), .i_ulp_tol(r_ulp_tol), .o_s1(s1)
    );

    fae_addsub u_addsub (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_s1(s1), .o_s2(s2)
    );

    fae_round u_round (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_s2(s2),
        .i_abs_tol(r_abs_tol), .o_res(res)
    );

    assign o_valid   = res.valid;
    assign o_equal   = res.equal;
    assign o_invalid = res.inv;
endmodule

// ===== rtl/fae_align.sv =====
module fae_align (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [fae_pkg::WordW-1:0]  i_a,
    input  logic [fae_pkg::WordW-1:0]  i_b,
    input  logic [fae_pkg::UlpW-1:0]   i_ulp_tol,
    output fae_pkg::t_s1               o_s1
);
    // d = b - a : treat as b + (-a)
    logic [fae_pkg::WordW-1:0]  na;
    logic                       a_big;
    logic [fae_pkg::WordW-1:0]  x, y;
    logic [fae_pkg::ExpW-1:0]   ex, ey, ex_e, ey_e, sh;
    logic [fae_pkg::SigW-1:0]   mx, my, shifted;
    logic [fae_pkg::SigW-1:0]   stk_mask;
    logic [fae_pkg::WordW-1:0]  ulp_dist;
    logic                       inv;
    fae_pkg::t_s1               n_s1, r_s1;

    always_comb begin
        na    = {~i_a[31], i_a[30:0]};
        a_big = na[30:0] > i_b[30:0];
        x     = a_big ? na : i_b;
        y     = a_big ? i_b : na;
        ex    = x[30:23];
        ey    = y[30:23];
        ex_e  = (ex == '0) ? 8'd1 : ex;
        ey_e  = (ey == '0) ? 8'd1 : ey;
        mx    = {1'b0, ex != '0, x[22:0], 3'b000};
        my    = {1'b0, ey != '0, y[22:0], 3'b000};
        sh    = ex_e - ey_e;
        stk_mask = ~({fae_pkg::SigW{1'b1}} << sh[4:0]);
        if (sh >= 8'd27) begin
            shifted = {{(fae_pkg::SigW-1){1'b0}}, my != '0};
        end else begin
            shifted = (my >> sh[4:0])
                    | {{(fae_pkg::SigW-1){1'b0}}, (my & stk_mask) != '0};
        end
        inv  = (i_a[30:23] == 8'hFF) || (i_b[30:23] == 8'hFF);
        ulp_dist = i_a - i_b;
        if (ulp_dist[31]) begin
            ulp_dist = 32'd0 - ulp_dist;
        end
        n_s1.valid     = i_valid;
        n_s1.inv       = inv;
        n_s1.same_sign = i_a[31] == i_b[31];
        n_s1.ulp_ok    = ulp_dist <= i_ulp_tol;
        n_s1.exp       = ex_e;
        n_s1.big       = mx;
        n_s1.lesser    = shifted;
        n_s1.sub       = x[31] != y[31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;
endmodule

// ===== rtl/fae_addsub.sv =====
module fae_addsub (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  fae_pkg::t_s1 i_s1,
    output fae_pkg::t_s2 o_s2
);
    fae_pkg::t_s2 n_s2, r_s2;

    always_comb begin
        n_s2.valid     = i_s1.valid;
        n_s2.inv       = i_s1.inv;
        n_s2.same_sign = i_s1.same_sign;
        n_s2.ulp_ok    = i_s1.ulp_ok;
        n_s2.exp       = i_s1.exp;
        n_s2.sum       = i_s1.sub ? ({1'b0, i_s1.big} - {1'b0, i_s1.lesser})
                                  : ({1'b0, i_s1.big} + {1'b0, i_s1.lesser});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else if (i_en) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;
endmodule

// ===== rtl/fae_round.sv =====
module fae_round (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  fae_pkg::t_s2              i_s2,
    input  logic [fae_pkg::TolW-1:0]  i_abs_tol,
    output fae_pkg::t_res             o_res
);
    // sum layout: bit 27 carry, bit 26 hidden, bits 2:0 guard, round, sticky
    logic [fae_pkg::SigW:0] s;
    logic [9:0]             e;
    logic [4:0]             shl;
    logic [fae_pkg::SigW:0] norm;
    logic [24:0]            rm;
    logic                   g, st;
    logic [30:0]            mag;
    logic [9:0]             ef;
    fae_pkg::t_res          n_res, r_res;

    always_comb begin
        s   = i_s2.sum;
        shl = 5'd0;
        if (s[27]) begin
            // carry out: shift right one, keep sticky
            norm = {1'b0, s[28:2], s[1] | s[0]};
            e    = {2'b00, i_s2.exp} + 10'd1;
        end else begin
            for (int i = 0; i < 27; i++) begin
                if ((s[26:0] >> (26 - i)) == 27'd1) begin
                    shl = 5'(i);
                end
            end
            // limit so the exponent does not drop below 1 (subnormal)
            if ({5'd0, shl} >= {2'b00, i_s2.exp}) begin
                shl = 5'(i_s2.exp - 8'd1);
            end
            norm = s << shl;
            e    = {2'b00, i_s2.exp} - {5'd0, shl};
            if (s[26:0] == '0) begin
                e = 10'd0;
            end
        end
        g   = norm[2];
        st  = norm[1] | norm[0];
        rm  = {1'b0, norm[26:3]} + {24'd0, g & (st | norm[3])};
        ef  = e;
        if (rm[24]) begin
            ef = e + 10'd1;
        end
        if (!rm[23] && !rm[24]) begin
            ef = 10'd0;
        end
        if (ef >= 10'd255) begin
            mag = 31'h7F80_0000;
        end else begin
            mag = {ef[7:0], rm[24] ? rm[23:1] : rm[22:0]};
        end
        n_res.valid = i_s2.valid;
        n_res.inv   = i_s2.inv;
        n_res.equal = !i_s2.inv && ((mag <= i_abs_tol) || (i_s2.same_sign && i_s2.ulp_ok));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.valid <= 1'b0;
        end else if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;
endmodule
